// File: hdl/gefa_pkg.sv
package gefa_pkg;

  // node and cost geometry
  localparam int NODE_COUNT = 256;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int ADDR_W     = 2 * NODE_W;
  localparam int COST_W     = 16;
  localparam int TIME_W     = 32;

  // robot geometry
  localparam int ROBOT_MAX  = 16;
  localparam int ROBOT_W    = $clog2(ROBOT_MAX);
  localparam int COUNT_W    = ROBOT_W + 1;

  // input word commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_INIT = 2'd1,
    CMD_TASK = 2'd2
  } gefa_cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD
  } gefa_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic ld_wr;
    logic init_wr;
    logic lat;
    logic del_issue;
    logic scan;
    logic upd;
  } gefa_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic out_busy;
  } gefa_stat_t;

endpackage

// File: hdl/gefa_ctrl.sv
module gefa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          command_i,
  output logic                in_stall_o,
  input  gefa_pkg::gefa_stat_t stat_i,
  output gefa_pkg::gefa_ctl_t  ctl_o
);
  import gefa_pkg::*;

  gefa_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (command_i)
            CMD_LOAD: ctl_o.ld_wr = 1'b1;
            CMD_INIT: ctl_o.init_wr = 1'b1;
            CMD_TASK: begin
              ctl_o.lat = 1'b1;
              state_d   = ST_DEL;
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        ctl_o.del_issue = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!stat_i.out_busy) begin
          ctl_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/gefa_dp.sv
module gefa_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gefa_pkg::gefa_ctl_t                 ctl_i,
  output gefa_pkg::gefa_stat_t                stat_o,
  input  logic                                cfg_we_i,
  input  logic [gefa_pkg::COUNT_W-1:0]        cfg_wdata_i,
  input  logic [gefa_pkg::NODE_W-1:0]         row_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]         col_node_i,
  input  logic [gefa_pkg::COST_W-1:0]         cost_value_i,
  input  logic [gefa_pkg::ROBOT_W-1:0]        robot_index_i,
  input  logic [gefa_pkg::NODE_W-1:0]         start_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]         pickup_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]         drop_node_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gefa_pkg::ROBOT_W-1:0]        chosen_robot_o,
  output logic [gefa_pkg::TIME_W-1:0]         finish_time_o
);
  import gefa_pkg::*;

  logic [COST_W-1:0]  cost_mem [0:NODE_COUNT*NODE_COUNT-1];
  logic [ADDR_W-1:0]  rd_addr;
  logic [COST_W-1:0]  rdata_q;

  logic [NODE_W-1:0]  end_node_q [0:ROBOT_MAX-1];
  logic [TIME_W-1:0]  busy_q     [0:ROBOT_MAX-1];

  logic [COUNT_W-1:0] robot_count_q;
  logic [COUNT_W-1:0] active;
  logic [ROBOT_W-1:0] last_idx;

  logic [NODE_W-1:0]  pickup_q, drop_q;
  logic [ROBOT_W-1:0] cnt_q;
  logic [ROBOT_W-1:0] cmp_idx_q;
  logic               cmp_vld_q;
  logic               del_vld_q;
  logic [COST_W-1:0]  del_q;
  logic [ROBOT_W-1:0] best_q;
  logic [TIME_W-1:0]  best_time_q;

  logic [TIME_W+1:0]  sum;
  logic [TIME_W-1:0]  cand;
  logic               take;

  logic               out_vld_q;
  logic [ROBOT_W-1:0] chosen_q;
  logic [TIME_W-1:0]  finish_q;

  // robot count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      robot_count_q <= cfg_wdata_i;
    end
  end

  // clamp the active count and find the last robot
  always_comb begin
    active = robot_count_q;
    if (robot_count_q == '0) begin
      active = COUNT_W'(1);
    end else if (robot_count_q > COUNT_W'(ROBOT_MAX)) begin
      active = COUNT_W'(ROBOT_MAX);
    end
  end
  assign last_idx = ROBOT_W'(active - COUNT_W'(1));

  // cost table: one write port, one registered read port
  assign rd_addr = ctl_i.del_issue ? {pickup_q, drop_q} : {end_node_q[cnt_q], pickup_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_wr) begin
      cost_mem[{row_node_i, col_node_i}] <= cost_value_i;
    end
    rdata_q <= cost_mem[rd_addr];
  end

  // task word capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.lat) begin
      pickup_q <= pickup_node_i;
      drop_q   <= drop_node_i;
    end
  end

  // robot scan sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      del_vld_q <= 1'b0;
    end else begin
      if (ctl_i.lat) begin
        cnt_q <= '0;
      end else if (ctl_i.scan) begin
        cnt_q <= cnt_q + ROBOT_W'(1);
      end
      cmp_idx_q <= cnt_q;
      cmp_vld_q <= ctl_i.scan;
      del_vld_q <= ctl_i.del_issue;
    end
  end

  assign stat_o.last = (cnt_q == last_idx);

  // delivery leg capture
  always_ff @(posedge clk_i) begin
    if (del_vld_q) begin
      del_q <= rdata_q;
    end
  end

  // candidate finish time, saturating
  assign sum  = {2'b00, busy_q[cmp_idx_q]}
              + {{(TIME_W+2-COST_W){1'b0}}, rdata_q}
              + {{(TIME_W+2-COST_W){1'b0}}, del_q};
  assign cand = (|sum[TIME_W+1:TIME_W]) ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  assign take = cmp_vld_q && ((cmp_idx_q == '0) || (cand < best_time_q));

  // running minimum, ties keep the lower index
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q      <= cmp_idx_q;
      best_time_q <= cand;
    end
  end

  // robot state: init and task update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROBOT_MAX; i++) begin
        end_node_q[i] <= '0;
        busy_q[i]     <= '0;
      end
    end else if (ctl_i.init_wr) begin
      end_node_q[robot_index_i] <= start_node_i;
      busy_q[robot_index_i]     <= '0;
    end else if (ctl_i.upd) begin
      end_node_q[best_q] <= drop_q;
      busy_q[best_q]     <= best_time_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.upd) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      chosen_q <= best_q;
      finish_q <= best_time_q;
    end
  end

  assign stat_o.out_busy = out_vld_q && out_stall_i;
  assign out_valid_o     = out_vld_q;
  assign chosen_robot_o  = chosen_q;
  assign finish_time_o   = finish_q;

  // checks
  a_out_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(ctl_i.upd))
    else $error("output word appeared without an update");

  a_upd_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.upd |-> !(out_vld_q && out_stall_i))
    else $error("update overwrote a stalled output word");

  a_cmp_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> $past(ctl_i.scan))
    else $error("compare without a preceding read");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.upd |-> (best_q <= last_idx))
    else $error("chosen robot beyond active count");

endmodule

// File: hdl/greedy_earliest_finish_assign.sv
// Greedy earliest-finish task assignment.
// Input channel (in_valid_i / in_stall_o) carries one word per accepted edge:
//   load writes one travel cost entry, init places a robot at a start node
//   with zero busy time, task picks the robot with the smallest busy time plus
//   pickup leg plus delivery leg (ties to the lower index) and updates it.
// Output channel (out_valid_o / out_stall_i) carries one word per task:
//   the chosen robot and its new busy time (Q28.4, saturating at all ones).
// cfg_we_i / cfg_wdata_i write the active robot count; write only when idle.
// Load and init complete in their accepting cycle. A task passes through
//   the accepting cycle, one delivery read, one cost-table read per robot
//   over the single read port, a drain cycle for the last compare and an
//   update cycle. The result word is valid from the cycle after the update
//   cycle.
// One item is in flight at a time; a waiting output word does not block the
//   next load or init, but a task holds in its update cycle until the output
//   register is free. A stalled output word holds steady.
// Reset clears robot state and the count to one; the cost table is not
//   cleared and must be loaded before any entry is used.
module greedy_earliest_finish_assign (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gefa_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [gefa_pkg::NODE_W-1:0]   row_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]   col_node_i,
  input  logic [gefa_pkg::COST_W-1:0]   cost_value_i,
  input  logic [gefa_pkg::ROBOT_W-1:0]  robot_index_i,
  input  logic [gefa_pkg::NODE_W-1:0]   start_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]   pickup_node_i,
  input  logic [gefa_pkg::NODE_W-1:0]   drop_node_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gefa_pkg::ROBOT_W-1:0]  chosen_robot_o,
  output logic [gefa_pkg::TIME_W-1:0]   finish_time_o
);
  import gefa_pkg::*;

  gefa_ctl_t  ctl;
  gefa_stat_t stat;

  // sequencer
  gefa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // cost table, robot state and output register
  gefa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_node_i     (row_node_i),
    .col_node_i     (col_node_i),
    .cost_value_i   (cost_value_i),
    .robot_index_i  (robot_index_i),
    .start_node_i   (start_node_i),
    .pickup_node_i  (pickup_node_i),
    .drop_node_i    (drop_node_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chosen_robot_o (chosen_robot_o),
    .finish_time_o  (finish_time_o)
  );

endmodule
